>>> sv/bar_pkg.sv
// ----------------------------------------------------------------------------
// Button auto-repeat package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bar_pkg;

  // Payload field widths.
  localparam int MASK_W    = 24;
  localparam int ELAPSED_W = 20;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters.
  localparam int BUTTONS_DEF   = 24;
  localparam int TIME_BITS_DEF = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(1);

  // Register reset values in microseconds.
  localparam logic [CFG_W-1:0] DELAY_RST    = CFG_W'(400000);
  localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(80000);

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/bar_if.sv
// ----------------------------------------------------------------------------
// Button auto-repeat channel interfaces
// Valid/ready channels for input frames, results and register writes.
// ----------------------------------------------------------------------------

// Input frame channel.
interface bar_in_if import bar_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    held_mask;
  logic [MASK_W-1:0]    pressed_mask;
  logic [MASK_W-1:0]    released_mask;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, held_mask, pressed_mask, released_mask, elapsed_us,
                  input ready);
  modport sink   (input valid, held_mask, pressed_mask, released_mask, elapsed_us,
                  output ready);
endinterface

// Result channel.
interface bar_out_if import bar_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] repeat_mask;
  logic              any_activity;

  modport source (output valid, repeat_mask, any_activity, input ready);
  modport sink   (input valid, repeat_mask, any_activity, output ready);
endinterface

// Register write channel.
interface bar_cfg_if import bar_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/bar_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/bar_rem_div.sv
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module bar_rem_div import bar_pkg::*; #(
  parameter int DVD_W = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [CFG_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [CFG_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   diff;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, div_r};
    rem_nxt = (trial >= {1'b0, div_r}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  end

  // Control: a count of remaining steps and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

>>> sv/button_auto_repeat.sv
// Frames: one frame at a time; the sequencer walks the buttons one by one, and
//   each held button whose hold time had already reached the delay also runs
//   the shared remainder unit before the walk moves on.
// Reset: hold times read as zero through per-button valid bits, no clearing pass;
//   registers return to 400000 us delay and 80000 us interval.
// ----------------------------------------------------------------------------
// Button auto-repeat
// Typematic repeat over a set of buttons, with hold times kept in a small RAM.
// ----------------------------------------------------------------------------
module button_auto_repeat import bar_pkg::*; #(
  parameter int BUTTONS   = BUTTONS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bar_in_if.sink    in_ch,
  bar_out_if.source out_ch,
  bar_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(BUTTONS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_DONE = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]     idx_r;
  logic [BUTTONS-1:0]   held_r;
  logic [BUTTONS-1:0]   pressed_r;
  logic [BUTTONS-1:0]   fire_r;
  logic [BUTTONS-1:0]   valid_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [ELAPSED_W-1:0] inc_r;
  logic                 any_r;
  logic [CFG_W-1:0]     delay_r;
  logic [CFG_W-1:0]     interval_r;
  logic                 out_valid_r;
  logic [MASK_W-1:0]    out_repeat_r;
  logic                 out_any_r;

  logic [BUTTONS-1:0]   held_ext;
  logic [BUTTONS-1:0]   pressed_ext;
  logic [MASK_W-1:0]    fire_out;
  logic                 in_acc;
  logic                 out_free;
  logic                 last_btn;

  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] hold_prev;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] delay_t;
  logic [CFG_W-1:0]     int_eff;
  logic                 held_cur;
  logic                 pressed_cur;
  logic                 before_ge;
  logic                 now_ge;
  logic                 first_cross;
  logic                 need_div;
  logic [TIME_BITS-1:0] step;
  logic [ELAPSED_W-1:0] inc;
  logic [TIME_BITS-1:0] wr_data;
  logic                 wr_en;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [CFG_W-1:0]     div_rem;
  logic                 hit;

  // Map the fixed-width masks onto the button range and back.
  for (genvar b = 0; b < BUTTONS; b++) begin : g_mask_in
    if (b < MASK_W) begin : g_live
      assign held_ext[b]    = in_ch.held_mask[b];
      assign pressed_ext[b] = in_ch.pressed_mask[b];
    end else begin : g_dead
      assign held_ext[b]    = 1'b0;
      assign pressed_ext[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask_out
    if (b < BUTTONS) begin : g_live
      assign fire_out[b] = fire_r[b];
    end else begin : g_dead
      assign fire_out[b] = 1'b0;
    end
  end

  // Handshakes.
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_btn  = (idx_r == LAST_IDX);

  // Per-button update: saturating hold time, first crossing of the delay.
  always_comb begin
    held_cur    = held_r[idx_r];
    pressed_cur = pressed_r[idx_r];
    hold_prev   = valid_r[idx_r] ? rd_data : '0;
    sum         = {1'b0, hold_prev} + (TIME_BITS + 1)'(elapsed_r);
    now         = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    delay_t     = TIME_BITS'(delay_r);
    int_eff     = (interval_r == '0) ? CFG_W'(1) : interval_r;
    before_ge   = (hold_prev >= delay_t);
    now_ge      = (now >= delay_t);
    first_cross = held_cur && !before_ge && now_ge;
    need_div    = held_cur && before_ge;
    step        = now - hold_prev;
    inc         = step[ELAPSED_W-1:0];
    wr_data     = held_cur ? now : '0;
  end

  // A repeat falls in this frame when the phase inside the interval wraps.
  assign hit = ({1'b0, div_rem} + (CFG_W + 1)'(inc_r)) >= {1'b0, int_eff};

  assign wr_en     = (state_r == S_LOAD);
  assign div_start = (state_r == S_LOAD) && need_div;

  // Hold-time store.
  bar_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (BUTTONS)
  ) u_hold_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Shared remainder unit: (hold_prev - delay) mod interval.
  bar_rem_div #(
    .DVD_W (TIME_BITS)
  ) u_rem_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hold_prev - delay_t),
    .divisor  (int_eff),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (need_div) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = last_btn ? S_DONE : S_READ;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = last_btn ? S_DONE : S_READ;
        end
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      delay_r     <= DELAY_RST;
      interval_r  <= INTERVAL_RST;
    end else begin
      state_r <= state_nxt;

      // Register writes.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DELAY:    delay_r    <= cfg_ch.data;
          REG_INTERVAL: interval_r <= cfg_ch.data;
          default: ;
        endcase
      end

      // Button index walks once per frame.
      if (state_r == S_IDLE) begin
        idx_r <= '0;
      end else if (state_nxt == S_READ) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (state_r == S_LOAD) begin
        valid_r[idx_r] <= 1'b1;
      end

      // Result register is freed by a transaction and refilled from the sequencer.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      held_r    <= held_ext;
      pressed_r <= pressed_ext;
      elapsed_r <= in_ch.elapsed_us;
      any_r     <= |{in_ch.held_mask, in_ch.pressed_mask, in_ch.released_mask};
      fire_r    <= '0;
    end
    if (state_r == S_LOAD) begin
      inc_r          <= inc;
      fire_r[idx_r]  <= pressed_cur || first_cross;
    end
    if (state_r == S_DIV && div_stat.done && hit) begin
      fire_r[idx_r] <= 1'b1;
    end
    if (state_r == S_DONE && out_free) begin
      out_repeat_r <= fire_out;
      out_any_r    <= any_r;
    end
  end

  // Ports.
  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.repeat_mask  = out_repeat_r;
  assign out_ch.any_activity = out_any_r;

endmodule

>>> sv/bar_checker.sv
// ----------------------------------------------------------------------------
// Button auto-repeat checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module bar_checker import bar_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] repeat_mask,
  input logic              any_activity,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // A result waits until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction");

  // The block works on one frame at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a frame is in progress");

  // A new result appears only at the end of a frame's walk.
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a frame in progress");

  // With no button activity nothing can fire.
  a_quiet_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !any_activity |-> repeat_mask == '0)
    else $error("repeat fired in a frame without activity");

  // Register writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind button_auto_repeat bar_checker u_bar_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .repeat_mask  (out_ch.repeat_mask),
  .any_activity (out_ch.any_activity),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready)
);

>>> verif/tb_button_auto_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat testbench
// Drives input frames into the typematic block and scores every result against
// a cycle-free predictor of hold times, first-repeat crossings and repeat
// intervals. It covers directed corner cases, a long hold past the widest
// delay, output backpressure and random press/hold/release sequences under
// several delay and interval settings.
// ----------------------------------------------------------------------------
module tb_button_auto_repeat;
  import bar_pkg::*;

  localparam int                  KEYS       = BUTTONS_DEF;
  localparam longint unsigned     HOLD_LIMIT = (64'd1 << TIME_BITS_DEF) - 64'd1;
  localparam logic [MASK_W-1:0]   ALL_KEYS   = '1;
  localparam logic [ELAPSED_W-1:0] MAX_STEP  = '1;
  localparam logic [CFG_W-1:0]    CFG_MAX    = '1;
  localparam int                  SETTLE     = KEYS * (TIME_BITS_DEF + 3) + 2;

  typedef struct {
    logic [MASK_W-1:0]    held;
    logic [MASK_W-1:0]    pressed;
    logic [MASK_W-1:0]    released;
    logic [ELAPSED_W-1:0] elapsed;
  } frame_t;

  typedef struct {
    logic [MASK_W-1:0] repeat_mask;
    logic              any_activity;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  bar_in_if  in_bus ();
  bar_out_if out_bus ();
  bar_cfg_if cfg_bus ();

  button_auto_repeat dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Predictor state: register copies and per-button hold times.
  logic [CFG_W-1:0] delay_cfg;
  logic [CFG_W-1:0] interval_cfg;
  longint unsigned  hold_us [KEYS];

  result_t pending_results [$];
  int      error_count = 0;
  bit      idle_enable = 1'b1;
  int      rx_hold_cycles = 0;

  always #1 clk = ~clk;

  // Works out the result of one frame and advances the hold times.
  function automatic void predict_frame(input frame_t f, output result_t r);
    longint unsigned dly;
    longint unsigned ivl;
    longint unsigned before_t;
    longint unsigned now_t;
    logic [MASK_W-1:0] fire;
    dly  = delay_cfg;
    ivl  = (interval_cfg == '0) ? 1 : interval_cfg;
    fire = f.pressed;
    for (int b = 0; b < KEYS; b++) begin
      if (f.held[b]) begin
        before_t = hold_us[b];
        now_t    = before_t + f.elapsed;
        if (now_t > HOLD_LIMIT) now_t = HOLD_LIMIT;
        hold_us[b] = now_t;
        if (before_t < dly && now_t >= dly) begin
          fire[b] = 1'b1;
        end else if (before_t >= dly && now_t >= dly &&
                     (now_t - dly) / ivl > (before_t - dly) / ivl) begin
          fire[b] = 1'b1;
        end
      end else begin
        hold_us[b] = 0;
      end
    end
    r.repeat_mask  = fire;
    r.any_activity = |(f.held | f.pressed | f.released);
  endfunction

  function automatic frame_t make_frame(input logic [MASK_W-1:0] held, pressed, released,
                                        input logic [ELAPSED_W-1:0] elapsed);
    frame_t f;
    f.held     = held;
    f.pressed  = pressed;
    f.released = released;
    f.elapsed  = elapsed;
    return f;
  endfunction

  // Picks a frame time scaled to the current interval, with some extremes.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int span;
    span = (interval_cfg > CFG_W'(MAX_STEP / 2)) ? int'(MAX_STEP) : 2 * int'(interval_cfg) + 1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ELAPSED_W'($urandom_range(0, int'(MAX_STEP)));
      2:       return MAX_STEP - ELAPSED_W'($urandom_range(0, 15));
      default: return ELAPSED_W'($urandom_range(0, span));
    endcase
  endfunction

  // Next frame of a physical key sequence; now and then a frame of noise.
  function automatic frame_t next_key_frame(inout logic [MASK_W-1:0] down);
    logic [MASK_W-1:0] next_down;
    if ($urandom_range(0, 9) == 0) begin
      return make_frame(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                        ELAPSED_W'($urandom));
    end
    next_down = down;
    for (int b = 0; b < KEYS; b++) begin
      if (down[b]) begin
        if ($urandom_range(0, 5) == 0) next_down[b] = 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        next_down[b] = 1'b1;
      end
    end
    next_key_frame = make_frame(next_down, next_down & ~down, down & ~next_down,
                                pick_elapsed());
    down = next_down;
  endfunction

  // Sends one frame and records its expected result once it is accepted.
  task automatic send_frame(input frame_t f);
    int      gap;
    result_t r;
    gap = idle_enable ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.held_mask     <= f.held;
    in_bus.pressed_mask  <= f.pressed;
    in_bus.released_mask <= f.released;
    in_bus.elapsed_us    <= f.elapsed;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_frame(f, r);
    pending_results.push_back(r);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic wait_quiet();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_DELAY:    delay_cfg = value;
      REG_INTERVAL: interval_cfg = value;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] dly, ivl);
    wait_quiet();
    write_reg(REG_DELAY, dly);
    write_reg(REG_INTERVAL, ivl);
  endtask

  // Corner cases at the reset timing: empty frame, press without hold, release
  // only, first crossing and interval repeats, held and released together.
  task automatic test_directed();
    send_frame(make_frame('0, '0, '0, '0));
    send_frame(make_frame('0, ALL_KEYS, '0, '0));
    send_frame(make_frame('0, '0, ALL_KEYS, '0));
    send_frame(make_frame(24'h000001, 24'h000001, '0, '0));
    send_frame(make_frame(24'h000001, '0, '0, 20'd399999));
    send_frame(make_frame(24'h000001, '0, '0, 20'd1));
    send_frame(make_frame(24'h000001, '0, '0, 20'd79999));
    send_frame(make_frame(24'h000001, '0, '0, 20'd1));
    send_frame(make_frame(24'h000001, '0, 24'h000001, 20'd80000));
    send_frame(make_frame('0, '0, 24'h000001, '0));
    send_frame(make_frame(ALL_KEYS, ALL_KEYS, ALL_KEYS, MAX_STEP));
    send_frame(make_frame(ALL_KEYS, '0, '0, MAX_STEP));
    send_frame(make_frame('0, '0, ALL_KEYS, '0));
    send_frame(make_frame(24'hAAAAAA, 24'h555555, '0, 20'h55555));
    send_frame(make_frame(24'h555555, '0, 24'hAAAAAA, 20'hAAAAA));
    send_frame(make_frame('0, '0, '0, '0));
  endtask

  // Zero delay and zero interval: repeats follow the interval rule from the
  // start of the hold, with the interval taken as one microsecond.
  task automatic test_zero_timing();
    set_timing('0, '0);
    send_frame(make_frame(24'h800001, 24'h800001, '0, '0));
    send_frame(make_frame(24'h800001, '0, '0, 20'd1));
    send_frame(make_frame(24'h800001, '0, '0, '0));
    send_frame(make_frame(24'h800001, '0, '0, 20'd3));
    send_frame(make_frame('0, '0, 24'h800001, '0));
  endtask

  // The receiver holds off for a long stretch while frames keep coming.
  task automatic test_output_stall();
    logic [MASK_W-1:0] down;
    set_timing(DELAY_RST, INTERVAL_RST);
    down = '0;
    rx_hold_cycles = 200;
    repeat (12) send_frame(next_key_frame(down));
  endtask

  // The sender pauses until the block has drained, then resumes.
  task automatic test_drain_pause();
    logic [MASK_W-1:0] down;
    down = '0;
    repeat (4) send_frame(next_key_frame(down));
    wait_quiet();
    repeat (4) send_frame(next_key_frame(down));
  endtask

  // One button held at the longest frame time well past the widest delay, so
  // the repeat phase is worked out on hold times wider than the registers;
  // afterwards a one-microsecond interval makes every held frame fire.
  task automatic test_long_hold();
    idle_enable = 1'b0;
    set_timing(CFG_MAX, CFG_MAX);
    send_frame(make_frame(24'h800000, 24'h800000, '0, MAX_STEP));
    repeat (59) send_frame(make_frame(24'h800000, '0, '0, MAX_STEP));
    wait_quiet();
    write_reg(REG_INTERVAL, CFG_W'(1));
    repeat (3) send_frame(make_frame(24'h800000, '0, '0, MAX_STEP));
    send_frame(make_frame('0, '0, 24'h800000, '0));
    idle_enable = 1'b1;
  endtask

  // Random key sequences over a series of timing settings, with and without
  // idle cycles on both sides.
  task automatic test_random_sequences();
    logic [CFG_W-1:0]  delays    [8];
    logic [CFG_W-1:0]  intervals [8];
    logic [MASK_W-1:0] down;
    delays    = '{DELAY_RST, CFG_W'(1), CFG_MAX, '0, CFG_W'(120000),
                  CFG_W'($urandom_range(0, 800000)), CFG_W'(2500),
                  CFG_W'($urandom_range(0, 4194303))};
    intervals = '{INTERVAL_RST, CFG_W'(1), CFG_MAX, '0, CFG_W'(30000),
                  CFG_W'($urandom_range(0, 250000)), CFG_W'(700),
                  CFG_W'($urandom_range(0, 4194303))};
    for (int p = 0; p < 8; p++) begin
      set_timing(delays[p], intervals[p]);
      idle_enable = (p % 3) != 2;
      down = '0;
      repeat (143) send_frame(next_key_frame(down));
    end
    idle_enable = 1'b1;
  endtask

  // Result scoreboard: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result repeat_mask=%h any_activity=%b",
                 $time, out_bus.repeat_mask, out_bus.any_activity);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.repeat_mask !== want.repeat_mask) begin
          $display("%0t: repeat_mask expected %h actual %h",
                   $time, want.repeat_mask, out_bus.repeat_mask);
          error_count++;
        end
        if (out_bus.any_activity !== want.any_activity) begin
          $display("%0t: any_activity expected %b actual %b",
                   $time, want.any_activity, out_bus.any_activity);
          error_count++;
        end
      end
    end
  end

  // Result receiver with random stalls and an occasional long hold-off.
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = idle_enable ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!(out_bus.valid && out_bus.ready)) @(posedge clk);
    end
  end

  // Test sequence.
  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.held_mask     <= '0;
    in_bus.pressed_mask  <= '0;
    in_bus.released_mask <= '0;
    in_bus.elapsed_us    <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_DELAY;
    cfg_bus.data         <= '0;
    delay_cfg    = DELAY_RST;
    interval_cfg = INTERVAL_RST;
    foreach (hold_us[b]) hold_us[b] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_timing();
    test_output_stall();
    test_drain_pause();
    test_long_hold();
    test_random_sequences();

    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_button_auto_repeat: PASS");
    end else begin
      $display("tb_button_auto_repeat: FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60_000_000;
    $display("%0t: timeout", $time);
    $display("tb_button_auto_repeat: FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/bar_pkg.sv
sv/bar_if.sv
sv/bar_ram.sv
sv/bar_rem_div.sv
sv/button_auto_repeat.sv
sv/bar_checker.sv
verif/tb_button_auto_repeat.sv
